>>> rtl/epfm_pkg.sv
// Shared types, widths and constants of the extrusion pressure fault monitor.
package epfm_pkg;

  typedef enum logic [2:0] {
    KIND_SAMPLE  = 3'd0,
    KIND_SUSPEND = 3'd1,
    KIND_RESUME  = 3'd2,
    KIND_CONSUME = 3'd3,
    KIND_ACK     = 3'd4
  } kind_t;

  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_SIGN     = 3'd1;
  localparam logic [2:0] REG_LOW_PRES = 3'd2;
  localparam logic [2:0] REG_PPV      = 3'd3;
  localparam logic [2:0] REG_NOISE    = 3'd4;
  localparam logic [2:0] REG_LOW_VEL  = 3'd5;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_NO_RISE  = 2'd1;
  localparam logic [1:0] FAULT_COLLAPSE = 2'd2;
  localparam logic [1:0] FAULT_BREAKOUT = 2'd3;

  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int DIV_N_W = 57;
  localparam int DIV_D_W = 17;
  localparam int DIV_C_W = $clog2(DIV_N_W);

  localparam logic signed [MUL_B_W-1:0] FILT_K    = 25'sd7864;
  localparam logic signed [MUL_B_W-1:0] BASE_K    = 25'sd67109;
  localparam logic signed [MUL_B_W-1:0] PEAK_K    = 25'sd65208;
  localparam logic signed [MUL_B_W-1:0] VEL_SCALE = 25'sd16000000;
  localparam logic signed [MUL_B_W-1:0] K_100     = 25'sd100;
  localparam logic signed [MUL_B_W-1:0] K_65      = 25'sd65;
  localparam logic signed [MUL_B_W-1:0] K_10      = 25'sd10;
  localparam logic signed [MUL_B_W-1:0] K_3       = 25'sd3;

  localparam logic signed [31:0] VEL_IDLE_MAX = 32'sd3276;
  localparam logic [31:0] MAX_DT_US         = 32'd100000;
  localparam logic [31:0] QUAL_TIME_US      = 32'd2000000;
  localparam logic [31:0] QUAL_DIST         = 32'd8192;
  localparam logic [31:0] BAD_LIMIT_US      = 32'd3000000;
  localparam logic [31:0] BREAKOUT_LIMIT_US = 32'd1000000;

endpackage

>>> rtl/epfm_mul.sv
// Shared signed multiplier with registered operands and registered product.
module epfm_mul import epfm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod,
  output logic                      vld
);

  logic signed [MUL_A_W-1:0] a_r;
  logic signed [MUL_B_W-1:0] b_r;
  logic signed [MUL_P_W-1:0] prod_r;
  logic                      stg_r;
  logic                      vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      stg_r <= go;
      vld_r <= stg_r;
    end
    if (go) begin
      a_r <= a;
      b_r <= b;
    end
    if (stg_r) begin
      prod_r <= MUL_P_W'(a_r) * MUL_P_W'(b_r);
    end
  end

  assign prod = prod_r;
  assign vld  = vld_r;

endmodule

>>> rtl/epfm_div.sv
// Restoring serial divider, one quotient bit per cycle.
module epfm_div import epfm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic               done,
  output logic [DIV_N_W-1:0] quo
);

  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] den_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_C_W-1:0] cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_D_W:0]   trial;
  logic               ge;
  logic [DIV_D_W:0]   diff;

  assign trial = {rem_r, quo_r[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_C_W'(DIV_N_W - 1);
        rem_r  <= '0;
        den_r  <= den;
        quo_r  <= num;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        quo_r <= {quo_r[DIV_N_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/extrusion_pressure_fault_monitor.sv
// Top level of the extrusion pressure fault monitor: sequencer, state and I/O.
// One result per input item. Suspend, resume, consume and acknowledge items, and
// samples that change nothing, go straight to the output step. A sample that
// reaches the velocity step makes three passes through the shared multiplier when
// the filament is still or moving back and eight when it moves forward, besides a
// 57-step serial velocity divider. The input is not ready while an item is being
// worked; a finished result waits in the output register while the next item is
// taken, and a result that finds that register still full waits until it drains.
// Configuration writes are always ready.
module extrusion_pressure_fault_monitor import epfm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic [31:0]        in_sample_time_us,
  input  logic signed [23:0] in_load,
  input  logic signed [31:0] in_extruder_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_pending_fault_code,
  output logic [1:0]         out_consumed_fault_code,
  output logic               out_monitor_active,
  output logic               out_breakout_marker,
  output logic signed [24:0] out_pressure_now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_FILT  = 13'b0000000000010,
    S_VMUL  = 13'b0000000000100,
    S_DIV   = 13'b0000000001000,
    S_BASE  = 13'b0000000010000,
    S_EXP   = 13'b0000000100000,
    S_PEAK  = 13'b0000001000000,
    S_PK100 = 13'b0000010000000,
    S_E65   = 13'b0000100000000,
    S_P10   = 13'b0001000000000,
    S_PK3   = 13'b0010000000000,
    S_DEC   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
    logic [33:0] s;
    s = {2'b0, a} + {1'b0, b};
    return (s > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
  endfunction

  state_t state_r, state_nxt;
  logic issued_r, issued_nxt;
  logic armed_r, armed_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic signed [31:0] last_pos_r, last_pos_nxt;
  logic signed [39:0] filt_r, filt_nxt, base_r, base_nxt;
  logic [31:0] fwd_time_r, fwd_time_nxt, fwd_dist_r, fwd_dist_nxt;
  logic signed [33:0] peak_r, peak_nxt;
  logic [31:0] bad_time_r, bad_time_nxt, brk_time_r, brk_time_nxt;
  logic brk_seen_r, brk_seen_nxt;
  logic [1:0] pend_r, pend_nxt, consumed_r, consumed_nxt;
  logic [7:0] susp_r, susp_nxt;
  logic hold_r, hold_nxt;
  logic en_r, en_nxt, sign_r, sign_nxt;
  logic [22:0] lp_r, lp_nxt, noise_r, noise_nxt, lv_r, lv_nxt;
  logic [23:0] ppv_r, ppv_nxt;
  logic signed [23:0] load_r, load_nxt;
  logic [16:0] dt_r, dt_nxt;
  logic signed [32:0] de_r, de_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic signed [33:0] p8_r, p8_nxt;
  logic [39:0] e_r, e_nxt;
  logic [40:0] em_r, em_nxt;
  logic signed [47:0] t1_r, t1_nxt;
  logic col1_r, col1_nxt, col2_r, col2_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_pend_r, out_pend_nxt, out_cons_r, out_cons_nxt;
  logic out_act_r, out_act_nxt, out_brk_r, out_brk_nxt;
  logic signed [24:0] out_pres_r, out_pres_nxt;

  logic do_clear;
  logic mul_go, mul_vld, div_start, div_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_prod, rnd16, rnd24;
  logic [DIV_N_W-1:0] div_q;

  logic signed [40:0] delta, sdelta;
  logic signed [41:0] rnd_p8, rnd_now;
  logic signed [33:0] p8_calc;
  logic signed [25:0] now26;
  logic signed [24:0] now25;
  logic [33:0] floor5, noise8, margin;
  logic [31:0] lp384;
  logic [31:0] dt_full;
  logic signed [32:0] de_calc;
  logic [32:0] abs_de;
  logic signed [32:0] dv_full;
  logic [30:0] dv;
  logic signed [31:0] vq;
  logic [39:0] e_calc;
  logic signed [33:0] pk_dec;
  logic [39:0] thr;
  logic qual, missing, collapsed, brk;
  logic [31:0] bad_new, brk_new;
  logic brk_seen_new;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign delta   = 41'(filt_r) - 41'(base_r);
  assign sdelta  = sign_r ? -delta : delta;
  assign rnd_p8  = 42'(sdelta) + 42'sd128;
  assign p8_calc = rnd_p8[41:8];
  assign rnd_now = 42'(sdelta) + 42'sd32768;
  assign now26   = rnd_now[41:16];
  assign now25   = (now26 > 26'sd16777215) ? 25'sh0FFFFFF :
                   (now26 < -26'sd16777216) ? 25'sh1000000 : now26[24:0];

  assign floor5 = 34'(noise_r) * 34'd1280;
  assign noise8 = {noise_r, 11'b0};
  assign lp384  = 32'(lp_r) * 32'd384;
  assign margin = (noise8 > 34'(lp384)) ? noise8 : 34'(lp384);

  assign dt_full = in_sample_time_us - last_time_r;
  assign de_calc = 33'(in_extruder_position) - 33'(last_pos_r);
  assign abs_de  = de_r[32] ? 33'(-de_r) : 33'(de_r);
  assign dv_full = 33'(v_r) - $signed({10'b0, lv_r});
  assign dv      = dv_full[32] ? 31'd0 : dv_full[30:0];

  assign rnd16 = mul_prod + 67'sd32768;
  assign rnd24 = mul_prod + 67'sd8388608;

  always_comb begin
    if (!de_r[32]) begin
      vq = (div_q[DIV_N_W-1:31] != '0) ? 32'sh7FFFFFFF : $signed(div_q[31:0]);
    end else begin
      vq = ((div_q[DIV_N_W-1:32] != '0) || (div_q[31] && div_q[30:0] != '0)) ?
           32'sh80000000 : $signed(-div_q[31:0]);
    end
  end

  assign e_calc = {9'b0, lp_r, 8'b0} + {1'b0, mul_prod[54:16]};
  assign pk_dec = rnd16[49:16];

  assign thr       = (40'({floor5, 2'b0}) > e_r) ? 40'({floor5, 2'b0}) : e_r;
  assign qual      = (fwd_time_r > QUAL_TIME_US) && (fwd_dist_r > QUAL_DIST);
  assign missing   = (42'(p8_r) <<< 2) < $signed({2'b0, thr});
  assign collapsed = col1_r && col2_r;
  assign brk       = qual && (v_r > $signed({8'b0, lv_r, 1'b0})) &&
                     ($signed(42'(p8_r)) > $signed({1'b0, em_r}));
  assign bad_new   = (qual && (missing || collapsed)) ? sat_add(bad_time_r, 33'(dt_r)) : '0;
  assign brk_new   = brk ? sat_add(brk_time_r, 33'(dt_r)) : '0;
  assign brk_seen_new = brk_seen_r || (brk_new > BREAKOUT_LIMIT_US);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_FILT: begin
        mul_a = $signed({{2{load_r[23]}}, load_r, 16'b0}) - 42'(filt_r);
        mul_b = FILT_K;
      end
      S_VMUL: begin
        mul_a = $signed(42'(abs_de));
        mul_b = VEL_SCALE;
      end
      S_BASE: begin
        mul_a = 42'(delta);
        mul_b = BASE_K;
      end
      S_EXP: begin
        mul_a = $signed(42'(dv));
        mul_b = $signed({1'b0, ppv_r});
      end
      S_PEAK: begin
        mul_a = 42'(peak_r);
        mul_b = PEAK_K;
      end
      S_PK100: begin
        mul_a = 42'(peak_r);
        mul_b = K_100;
      end
      S_E65: begin
        mul_a = $signed({2'b0, e_r});
        mul_b = K_65;
      end
      S_P10: begin
        mul_a = 42'(p8_r);
        mul_b = K_10;
      end
      S_PK3: begin
        mul_a = 42'(peak_r);
        mul_b = K_3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;  issued_nxt = issued_r;  armed_nxt = armed_r;
    last_time_nxt = last_time_r;  last_pos_nxt = last_pos_r;
    filt_nxt = filt_r;  base_nxt = base_r;
    fwd_time_nxt = fwd_time_r;  fwd_dist_nxt = fwd_dist_r;  peak_nxt = peak_r;
    bad_time_nxt = bad_time_r;  brk_time_nxt = brk_time_r;  brk_seen_nxt = brk_seen_r;
    pend_nxt = pend_r;  consumed_nxt = consumed_r;  susp_nxt = susp_r;  hold_nxt = hold_r;
    en_nxt = en_r;  sign_nxt = sign_r;  lp_nxt = lp_r;  ppv_nxt = ppv_r;
    noise_nxt = noise_r;  lv_nxt = lv_r;
    load_nxt = load_r;  dt_nxt = dt_r;  de_nxt = de_r;  v_nxt = v_r;  p8_nxt = p8_r;
    e_nxt = e_r;  em_nxt = em_r;  t1_nxt = t1_r;  col1_nxt = col1_r;  col2_nxt = col2_r;
    out_valid_nxt = out_valid_r;  out_pend_nxt = out_pend_r;  out_cons_nxt = out_cons_r;
    out_act_nxt = out_act_r;  out_brk_nxt = out_brk_r;  out_pres_nxt = out_pres_r;
    do_clear = 1'b0;  mul_go = 1'b0;  div_start = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          consumed_nxt = FAULT_NONE;
          state_nxt    = S_OUT;
          case (in_kind)
            KIND_SAMPLE: begin
              if (en_r && susp_r == '0) begin
                last_time_nxt = in_sample_time_us;
                last_pos_nxt  = in_extruder_position;
                if (!armed_r) begin
                  armed_nxt = 1'b1;
                  filt_nxt  = {in_load, 16'b0};
                  base_nxt  = {in_load, 16'b0};
                end else begin
                  load_nxt = in_load;
                  dt_nxt   = dt_full[16:0];
                  de_nxt   = de_calc;
                  if (dt_full != '0 && dt_full < MAX_DT_US) begin
                    state_nxt = S_FILT;
                  end
                end
              end
            end
            KIND_SUSPEND: begin
              if (susp_r != 8'hFF) begin
                susp_nxt = susp_r + 1'b1;
              end
            end
            KIND_RESUME: begin
              if (susp_r != '0) begin
                susp_nxt = susp_r - 1'b1;
                if (susp_r == 8'd1) begin
                  armed_nxt = 1'b0;
                  do_clear  = 1'b1;
                end
              end
            end
            KIND_CONSUME: begin
              consumed_nxt = pend_r;
              pend_nxt     = FAULT_NONE;
              if (pend_r != FAULT_NONE && !hold_r) begin
                hold_nxt = 1'b1;
                if (susp_r != 8'hFF) begin
                  susp_nxt = susp_r + 1'b1;
                end
              end
            end
            KIND_ACK: begin
              if (hold_r) begin
                hold_nxt = 1'b0;
                if (susp_r != '0) begin
                  susp_nxt = susp_r - 1'b1;
                end
              end
              pend_nxt  = FAULT_NONE;
              armed_nxt = 1'b0;
              do_clear  = 1'b1;
            end
            default: begin
              consumed_nxt = FAULT_NONE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (!issued_r) begin
          div_start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          issued_nxt = 1'b0;
          v_nxt      = vq;
          if (vq <= VEL_IDLE_MAX) begin
            state_nxt = S_BASE;
          end else begin
            fwd_time_nxt = sat_add(fwd_time_r, 33'(dt_r));
            if (de_r > 33'sd0) begin
              fwd_dist_nxt = sat_add(fwd_dist_r, 33'(de_r));
            end
            p8_nxt    = p8_calc;
            state_nxt = S_EXP;
          end
        end
      end
      S_DEC: begin
        bad_time_nxt = bad_new;
        brk_time_nxt = brk_new;
        brk_seen_nxt = brk_seen_new;
        if (bad_new > BAD_LIMIT_US && pend_r == FAULT_NONE) begin
          pend_nxt = collapsed ? (brk_seen_new ? FAULT_BREAKOUT : FAULT_COLLAPSE) :
                     FAULT_NO_RISE;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pend_nxt  = pend_r;
          out_cons_nxt  = consumed_r;
          out_act_nxt   = en_r && (susp_r == '0);
          out_brk_nxt   = brk_seen_r;
          out_pres_nxt  = now25;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        if (!issued_r) begin
          mul_go     = 1'b1;
          issued_nxt = 1'b1;
        end else if (mul_vld) begin
          issued_nxt = 1'b0;
          case (state_r)
            S_FILT: begin
              filt_nxt  = filt_r + rnd16[55:16];
              state_nxt = S_VMUL;
            end
            S_VMUL: begin
              state_nxt = S_DIV;
            end
            S_BASE: begin
              base_nxt  = base_r + rnd24[63:24];
              do_clear  = 1'b1;
              state_nxt = S_OUT;
            end
            S_EXP: begin
              e_nxt     = (e_calc > 40'(floor5)) ? e_calc : 40'(floor5);
              state_nxt = S_PEAK;
            end
            S_PEAK: begin
              peak_nxt  = (p8_r > pk_dec) ? p8_r : pk_dec;
              em_nxt    = 41'(e_r) + 41'(margin);
              state_nxt = S_PK100;
            end
            S_PK100: begin
              t1_nxt    = mul_prod[47:0];
              state_nxt = S_E65;
            end
            S_E65: begin
              col1_nxt  = t1_r > $signed(mul_prod[47:0]);
              state_nxt = S_P10;
            end
            S_P10: begin
              t1_nxt    = mul_prod[47:0];
              state_nxt = S_PK3;
            end
            S_PK3: begin
              col2_nxt  = t1_r < $signed(mul_prod[47:0]);
              state_nxt = S_DEC;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
    endcase

    if (do_clear) begin
      fwd_time_nxt = '0;  fwd_dist_nxt = '0;  bad_time_nxt = '0;  brk_time_nxt = '0;
      brk_seen_nxt = 1'b0;  peak_nxt = '0;
    end

    if (cfg_valid && cfg_index <= REG_LOW_VEL) begin
      case (cfg_index)
        REG_ENABLE:   en_nxt    = cfg_data[0];
        REG_SIGN:     sign_nxt  = cfg_data[0];
        REG_LOW_PRES: lp_nxt    = cfg_data[22:0];
        REG_PPV:      ppv_nxt   = cfg_data;
        REG_NOISE:    noise_nxt = cfg_data[22:0];
        default:      lv_nxt    = cfg_data[22:0];
      endcase
      armed_nxt = 1'b0;
      pend_nxt  = FAULT_NONE;
      fwd_time_nxt = '0;  fwd_dist_nxt = '0;  bad_time_nxt = '0;  brk_time_nxt = '0;
      brk_seen_nxt = 1'b0;  peak_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  issued_r <= 1'b0;  armed_r <= 1'b0;
      last_time_r <= '0;  last_pos_r <= '0;  filt_r <= '0;  base_r <= '0;
      fwd_time_r <= '0;  fwd_dist_r <= '0;  peak_r <= '0;
      bad_time_r <= '0;  brk_time_r <= '0;  brk_seen_r <= 1'b0;
      pend_r <= FAULT_NONE;  consumed_r <= FAULT_NONE;  susp_r <= '0;  hold_r <= 1'b0;
      en_r <= 1'b0;  sign_r <= 1'b0;  lp_r <= '0;  ppv_r <= '0;
      noise_r <= 23'd256;  lv_r <= 23'd52429;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  issued_r <= issued_nxt;  armed_r <= armed_nxt;
      last_time_r <= last_time_nxt;  last_pos_r <= last_pos_nxt;
      filt_r <= filt_nxt;  base_r <= base_nxt;
      fwd_time_r <= fwd_time_nxt;  fwd_dist_r <= fwd_dist_nxt;  peak_r <= peak_nxt;
      bad_time_r <= bad_time_nxt;  brk_time_r <= brk_time_nxt;  brk_seen_r <= brk_seen_nxt;
      pend_r <= pend_nxt;  consumed_r <= consumed_nxt;  susp_r <= susp_nxt;
      hold_r <= hold_nxt;
      en_r <= en_nxt;  sign_r <= sign_nxt;  lp_r <= lp_nxt;  ppv_r <= ppv_nxt;
      noise_r <= noise_nxt;  lv_r <= lv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    load_r <= load_nxt;  dt_r <= dt_nxt;  de_r <= de_nxt;  v_r <= v_nxt;  p8_r <= p8_nxt;
    e_r <= e_nxt;  em_r <= em_nxt;  t1_r <= t1_nxt;  col1_r <= col1_nxt;  col2_r <= col2_nxt;
    out_pend_r <= out_pend_nxt;  out_cons_r <= out_cons_nxt;  out_act_r <= out_act_nxt;
    out_brk_r <= out_brk_nxt;  out_pres_r <= out_pres_nxt;
  end

  epfm_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod),
    .vld  (mul_vld)
  );

  epfm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (mul_prod[DIV_N_W-1:0]),
    .den  (dt_r),
    .done (div_done),
    .quo  (div_q)
  );

  assign out_valid               = out_valid_r;
  assign out_pending_fault_code  = out_pend_r;
  assign out_consumed_fault_code = out_cons_r;
  assign out_monitor_active      = out_act_r;
  assign out_breakout_marker     = out_brk_r;
  assign out_pressure_now        = out_pres_r;

  a_cfg_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index <= REG_LOW_VEL |=> !armed_r)
    else $error("register write left the monitor armed");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the velocity step");

  a_mul_issued: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld |-> issued_r)
    else $error("product arrived with no multiply outstanding");

endmodule
